>>> hw/rtl/dtq_pkg.sv
package dtq_pkg;

	localparam int unsigned DL_W      = 32;
	localparam int unsigned CONN_W    = 16;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned ORD_W     = 16;
	localparam int unsigned WAIT_W    = 16;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	// order tags are renumbered before this value would be handed out
	localparam logic [ORD_W-1:0]  ORDER_LIMIT = 16'hFFFF;
	localparam logic [WAIT_W-1:0] WAIT_RESET  = 16'd20;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_ADDED   = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_EXPIRED = 3'd2,
		STAT_NONE    = 3'd3,
		STAT_REMOVED = 3'd4
	} status_t;

	typedef enum logic {
		REG_WAIT = 1'b0,
		REG_KICK = 1'b1
	} reg_sel_t;

	typedef enum logic [1:0] {
		SCAN_MIN_ALL,
		SCAN_MIN_OPEN,
		SCAN_ORDER,
		SCAN_MATCH
	} scan_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_SLOT,
		S_ADD_WRITE,
		S_DEL,
		S_TICK_FIRST,
		S_TICK_APPLY,
		S_TICK_REARM,
		S_TICK_EARLY,
		S_TICK_NEXT,
		S_RN_SCAN,
		S_FINAL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       start;
		scan_mode_t mode;
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [DL_W-1:0]   deadline;
		logic [CONN_W-1:0] conn;
		logic [SEQ_W-1:0]  seq;
	} scan_res_t;

	typedef struct packed {
		logic dl;
		logic conn;
		logic seq;
		logic ord;
	} store_we_t;

endpackage

>>> hw/rtl/dtq_store.sv
module dtq_store
	import dtq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  store_we_t         we,
	input  logic [IW-1:0]     waddr,
	input  logic [DL_W-1:0]   wr_deadline,
	input  logic [CONN_W-1:0] wr_conn,
	input  logic [SEQ_W-1:0]  wr_seq,
	input  logic [ORD_W-1:0]  wr_order,
	input  logic [IW-1:0]     raddr,
	output logic [DL_W-1:0]   rd_deadline,
	output logic [CONN_W-1:0] rd_conn,
	output logic [SEQ_W-1:0]  rd_seq,
	output logic [ORD_W-1:0]  rd_order
);

	logic [DL_W-1:0]   mem_dl   [DEPTH];
	logic [CONN_W-1:0] mem_conn [DEPTH];
	logic [SEQ_W-1:0]  mem_seq  [DEPTH];
	logic [ORD_W-1:0]  mem_ord  [DEPTH];

	always_ff @(posedge clk) begin
		if (we.dl) begin
			mem_dl[waddr] <= wr_deadline;
		end
		if (we.conn) begin
			mem_conn[waddr] <= wr_conn;
		end
		if (we.seq) begin
			mem_seq[waddr] <= wr_seq;
		end
		if (we.ord) begin
			mem_ord[waddr] <= wr_order;
		end
	end

	always_ff @(posedge clk) begin
		rd_deadline <= mem_dl[raddr];
		rd_conn     <= mem_conn[raddr];
		rd_seq      <= mem_seq[raddr];
		rd_order    <= mem_ord[raddr];
	end

endmodule

>>> hw/rtl/dtq_scan.sv
module dtq_scan
	import dtq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [DEPTH-1:0]  elig,
	input  logic [CONN_W-1:0] match_conn,
	input  logic [DL_W-1:0]   rd_deadline,
	input  logic [CONN_W-1:0] rd_conn,
	input  logic [SEQ_W-1:0]  rd_seq,
	input  logic [ORD_W-1:0]  rd_order,
	output logic [IW-1:0]     raddr,
	output logic              hit,
	output logic [IW-1:0]     hit_idx,
	output logic [IW-1:0]     free_idx,
	output logic [IW-1:0]     best_idx,
	output scan_res_t         res,
	output logic              done
);

	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam int unsigned   KEY_W    = DL_W + ORD_W;

	scan_mode_t        mode_q;
	logic              run_q;
	logic [IW-1:0]     cnt_q;
	logic              valid_s1;
	logic              last_s1;
	logic [IW-1:0]     idx_s1;
	logic              done_q;
	logic              found_q;
	logic [IW-1:0]     best_idx_q;
	logic [IW-1:0]     free_idx_q;
	logic [DL_W-1:0]   best_dl_q;
	logic [ORD_W-1:0]  best_ord_q;
	logic [CONN_W-1:0] best_conn_q;
	logic [SEQ_W-1:0]  best_seq_q;

	logic              eligible;
	logic [KEY_W-1:0]  key_new;
	logic [KEY_W-1:0]  key_best;
	logic              better;

	assign raddr = cnt_q;

	// the single comparator: deadline then order tag, or order tag alone
	always_comb begin
		eligible = valid_s1 && elig[idx_s1];
		if (mode_q == SCAN_ORDER) begin
			key_new  = {{DL_W{1'b0}}, rd_order};
			key_best = {{DL_W{1'b0}}, best_ord_q};
		end else begin
			key_new  = {rd_deadline, rd_order};
			key_best = {best_dl_q, best_ord_q};
		end
		better = eligible && (!found_q || (key_new < key_best));
	end

	assign hit     = eligible && (mode_q == SCAN_MATCH) && (rd_conn == match_conn);
	assign hit_idx = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= SCAN_MIN_ALL;
			run_q    <= 1'b0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (ctl.start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				mode_q <= ctl.mode;
			end else if (run_q) begin
				cnt_q <= cnt_q + IW'(1);
				if (cnt_q == LAST_IDX) begin
					run_q <= 1'b0;
				end
			end
			valid_s1 <= run_q;
			last_s1  <= run_q && (cnt_q == LAST_IDX);
			done_q   <= valid_s1 && last_s1;
			if (ctl.start) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (better) begin
			best_idx_q  <= idx_s1;
			best_dl_q   <= rd_deadline;
			best_ord_q  <= rd_order;
			best_conn_q <= rd_conn;
			best_seq_q  <= rd_seq;
		end
		if (valid_s1 && !elig[idx_s1]) begin
			free_idx_q <= idx_s1;
		end
	end

	assign done         = done_q;
	assign best_idx     = best_idx_q;
	assign free_idx     = free_idx_q;
	assign res.found    = found_q;
	assign res.deadline = best_dl_q;
	assign res.conn     = best_conn_q;
	assign res.seq      = best_seq_q;

endmodule

>>> hw/rtl/deadline_timer_queue.sv
// Timer table of QUEUE_DEPTH entries kept in small memories, walked one entry per cycle by a
// single scan engine with one comparator. An add or a delete takes two passes, a full-table add
// one pass, a clear none. A tick takes one pass when nothing is due and otherwise two passes per
// expired timer plus one, each expired word leaving through the output register as soon as it
// is taken. When the 16-bit order tag runs out, the held timers are renumbered first, which costs
// one extra pass per held timer plus one. in_ready is high only between items; results are words
// with last set on the final one of each item. wait_time sits at byte 0 and kick_on_timeout at
// byte 4.
module deadline_timer_queue
	import dtq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [CONN_W-1:0]    conn_id,
	input  logic [SEQ_W-1:0]     sequence_req,
	input  logic [DL_W-1:0]      now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [CONN_W-1:0]    expired_conn,
	output logic [SEQ_W-1:0]     expired_sequence,
	output logic [CNT_OUT_W-1:0] removed_count,
	output logic [CNT_OUT_W-1:0] queue_count,
	output logic [DL_W-1:0]      earliest_deadline,
	output logic                 last
);

	localparam int unsigned    IW      = $clog2(QUEUE_DEPTH);
	localparam int unsigned    CW      = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0]  DEPTH_C = CW'(QUEUE_DEPTH);

	// configuration
	logic [WAIT_W-1:0] wait_q;
	logic              kick_q;
	logic              cfg_we;
	reg_sel_t          cfg_sel;

	// sequencer and table bookkeeping
	state_t            state_q, state_d;
	scan_mode_t        scan_mode_q, scan_mode_d;
	logic              scan_start;
	logic              emit_load;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [QUEUE_DEPTH-1:0] open_q;
	logic [QUEUE_DEPTH-1:0] ranked_q;
	logic [QUEUE_DEPTH-1:0] elig;
	logic [CW-1:0]     held_q;
	logic [ORD_W-1:0]  order_q;
	logic [IW-1:0]     rn_k_q;
	logic              rn_from_tick_q;
	logic              accept;

	// current item
	logic [CONN_W-1:0] conn_q;
	logic [SEQ_W-1:0]  seqreq_q;
	logic [DL_W-1:0]   now_q;
	logic [DL_W-1:0]   arm_dl_q;
	logic [DL_W:0]     arm_sum;
	logic [IW-1:0]     slot_q;
	logic [IW-1:0]     cand_idx_q;
	logic [CONN_W-1:0] cand_conn_q;
	logic [SEQ_W-1:0]  cand_seq_q;

	// word waiting for the output register
	status_t           pend_status_q;
	logic [CONN_W-1:0] pend_conn_q;
	logic [SEQ_W-1:0]  pend_seq_q;
	logic [CW-1:0]     pend_removed_q;
	logic [CW-1:0]     pend_held_q;
	logic [DL_W-1:0]   pend_earliest_q;
	logic              pend_last_q;

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic [CONN_W-1:0] exp_conn_q;
	logic [SEQ_W-1:0]  exp_seq_q;
	logic [CW-1:0]     removed_q;
	logic [CW-1:0]     count_q;
	logic [DL_W-1:0]   earliest_q;
	logic              last_q;

	// store and scan
	store_we_t         st_we;
	logic [IW-1:0]     st_waddr;
	logic [ORD_W-1:0]  st_word;
	logic [IW-1:0]     st_raddr;
	logic [DL_W-1:0]   rd_deadline;
	logic [CONN_W-1:0] rd_conn;
	logic [SEQ_W-1:0]  rd_seq;
	logic [ORD_W-1:0]  rd_order;
	scan_ctl_t         scan_ctl;
	logic              hit;
	logic [IW-1:0]     hit_idx;
	logic [IW-1:0]     free_idx;
	logic [IW-1:0]     best_idx;
	scan_res_t         sres;
	logic              scan_done;
	logic              due;

	assign pready  = 1'b1;
	assign cfg_sel = reg_sel_t'(paddr[2]);
	assign cfg_we  = psel && penable && pwrite;
	assign prdata  = (cfg_sel == REG_KICK) ? PDATA_W'(kick_q) : PDATA_W'(wait_q);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// deadline saturates at the top of the time range
	assign arm_sum = {1'b0, now} + (DL_W + 1)'(wait_q);

	assign due = sres.found && (sres.deadline <= now_q);

	always_comb begin
		case (scan_mode_q)
			SCAN_MIN_OPEN: elig = valid_q & ~open_q;
			SCAN_ORDER:    elig = valid_q & ~ranked_q;
			default:       elig = valid_q;
		endcase
	end

	assign scan_ctl.start = scan_start;
	assign scan_ctl.mode  = scan_mode_d;

	dtq_store #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW)
	) u_store (
		.clk         (clk),
		.we          (st_we),
		.waddr       (st_waddr),
		.wr_deadline (arm_dl_q),
		.wr_conn     (conn_q),
		.wr_seq      (seqreq_q),
		.wr_order    (st_word),
		.raddr       (st_raddr),
		.rd_deadline (rd_deadline),
		.rd_conn     (rd_conn),
		.rd_seq      (rd_seq),
		.rd_order    (rd_order)
	);

	dtq_scan #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.elig        (elig),
		.match_conn  (conn_q),
		.rd_deadline (rd_deadline),
		.rd_conn     (rd_conn),
		.rd_seq      (rd_seq),
		.rd_order    (rd_order),
		.raddr       (st_raddr),
		.hit         (hit),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx),
		.best_idx    (best_idx),
		.res         (sres),
		.done        (scan_done)
	);

	always_comb begin
		st_we    = '0;
		st_waddr = slot_q;
		st_word  = order_q;
		case (state_q)
			S_ADD_WRITE: begin
				st_we = '1;
			end
			S_TICK_REARM: begin
				st_we.dl  = 1'b1;
				st_we.ord = 1'b1;
				st_waddr  = cand_idx_q;
			end
			S_RN_SCAN: begin
				if (scan_done && sres.found) begin
					st_we.ord = 1'b1;
					st_waddr  = best_idx;
					st_word   = ORD_W'(rn_k_q);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		scan_start  = 1'b0;
		scan_mode_d = scan_mode_q;
		emit_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_ADD: begin
							scan_start  = 1'b1;
							scan_mode_d = SCAN_MIN_ALL;
							state_d     = (held_q >= DEPTH_C) ? S_FINAL : S_ADD_SLOT;
						end
						ACT_TICK: begin
							scan_start  = 1'b1;
							scan_mode_d = SCAN_MIN_ALL;
							state_d     = S_TICK_FIRST;
						end
						ACT_DELETE: begin
							scan_start  = 1'b1;
							scan_mode_d = SCAN_MATCH;
							state_d     = S_DEL;
						end
						default: begin
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_ADD_SLOT: begin
				if (scan_done) begin
					if (order_q == ORDER_LIMIT) begin
						scan_start  = 1'b1;
						scan_mode_d = SCAN_ORDER;
						state_d     = S_RN_SCAN;
					end else begin
						state_d = S_ADD_WRITE;
					end
				end
			end
			S_ADD_WRITE: begin
				scan_start  = 1'b1;
				scan_mode_d = SCAN_MIN_ALL;
				state_d     = S_FINAL;
			end
			S_DEL: begin
				if (scan_done) begin
					scan_start  = 1'b1;
					scan_mode_d = SCAN_MIN_ALL;
					state_d     = S_FINAL;
				end
			end
			S_TICK_FIRST: begin
				if (scan_done) begin
					if (sres.found && (sres.deadline < now_q)) begin
						state_d = S_TICK_APPLY;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_TICK_APPLY: begin
				if (kick_q) begin
					scan_start  = 1'b1;
					scan_mode_d = SCAN_MIN_ALL;
					state_d     = S_TICK_EARLY;
				end else if (order_q == ORDER_LIMIT) begin
					scan_start  = 1'b1;
					scan_mode_d = SCAN_ORDER;
					state_d     = S_RN_SCAN;
				end else begin
					state_d = S_TICK_REARM;
				end
			end
			S_TICK_REARM: begin
				scan_start  = 1'b1;
				scan_mode_d = SCAN_MIN_ALL;
				state_d     = S_TICK_EARLY;
			end
			S_TICK_EARLY: begin
				if (scan_done) begin
					scan_start  = 1'b1;
					scan_mode_d = SCAN_MIN_OPEN;
					state_d     = S_TICK_NEXT;
				end
			end
			S_TICK_NEXT: begin
				if (scan_done) begin
					state_d = S_EMIT;
				end
			end
			S_RN_SCAN: begin
				// one pass per rank: lowest unranked tag gets the next rank
				if (scan_done) begin
					if (sres.found) begin
						scan_start  = 1'b1;
						scan_mode_d = SCAN_ORDER;
					end else begin
						state_d = rn_from_tick_q ? S_TICK_REARM : S_ADD_WRITE;
					end
				end
			end
			S_FINAL: begin
				if (scan_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_load = 1'b1;
					state_d   = pend_last_q ? S_IDLE : S_TICK_APPLY;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q         <= WAIT_RESET;
			kick_q         <= 1'b0;
			state_q        <= S_IDLE;
			scan_mode_q    <= SCAN_MIN_ALL;
			valid_q        <= '0;
			open_q         <= '0;
			ranked_q       <= '0;
			held_q         <= '0;
			order_q        <= '0;
			rn_k_q         <= '0;
			rn_from_tick_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_sel == REG_KICK) begin
					kick_q <= pwdata[0];
				end else begin
					wait_q <= pwdata[WAIT_W-1:0];
				end
			end
			if (scan_start) begin
				scan_mode_q <= scan_mode_d;
			end
			if (scan_start && (scan_mode_d == SCAN_ORDER) && (state_q != S_RN_SCAN)) begin
				ranked_q       <= '0;
				rn_k_q         <= '0;
				rn_from_tick_q <= (state_q == S_TICK_APPLY);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (action_t'(action) == ACT_CLEAR)) begin
						valid_q <= '0;
						held_q  <= '0;
						order_q <= '0;
					end
					if (accept && (action_t'(action) == ACT_TICK)) begin
						open_q <= '0;
					end
				end
				S_ADD_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					held_q          <= held_q + CW'(1);
					order_q         <= order_q + ORD_W'(1);
				end
				S_DEL: begin
					if (hit) begin
						valid_q[hit_idx] <= 1'b0;
						held_q           <= held_q - CW'(1);
					end
				end
				S_TICK_APPLY: begin
					open_q[cand_idx_q] <= 1'b1;
					if (kick_q) begin
						valid_q[cand_idx_q] <= 1'b0;
						held_q              <= held_q - CW'(1);
					end
				end
				S_TICK_REARM: begin
					order_q <= order_q + ORD_W'(1);
				end
				S_RN_SCAN: begin
					if (scan_done) begin
						if (sres.found) begin
							ranked_q[best_idx] <= 1'b1;
							rn_k_q             <= rn_k_q + IW'(1);
						end else begin
							order_q <= ORD_W'(held_q);
						end
					end
				end
				default: ;
			endcase
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conn_q          <= conn_id;
			seqreq_q        <= sequence_req;
			now_q           <= now;
			arm_dl_q        <= arm_sum[DL_W] ? '1 : arm_sum[DL_W-1:0];
			pend_conn_q     <= '0;
			pend_seq_q      <= '0;
			pend_last_q     <= 1'b1;
			pend_earliest_q <= '0;
			pend_held_q     <= '0;
			pend_removed_q  <= '0;
			case (action_t'(action))
				ACT_ADD: begin
					pend_status_q <= (held_q >= DEPTH_C) ? STAT_FULL : STAT_ADDED;
				end
				ACT_TICK: begin
					pend_status_q <= STAT_NONE;
				end
				ACT_DELETE: begin
					pend_status_q <= STAT_REMOVED;
				end
				default: begin
					pend_status_q  <= STAT_REMOVED;
					pend_removed_q <= held_q;
				end
			endcase
		end
		case (state_q)
			S_ADD_SLOT: begin
				if (scan_done) begin
					slot_q <= free_idx;
				end
			end
			S_DEL: begin
				if (hit) begin
					pend_removed_q <= pend_removed_q + CW'(1);
				end
			end
			S_TICK_FIRST: begin
				if (scan_done) begin
					pend_earliest_q <= sres.found ? sres.deadline : '0;
					pend_held_q     <= held_q;
					cand_idx_q      <= best_idx;
					cand_conn_q     <= sres.conn;
					cand_seq_q      <= sres.seq;
				end
			end
			S_TICK_EARLY: begin
				if (scan_done) begin
					pend_status_q   <= STAT_EXPIRED;
					pend_conn_q     <= cand_conn_q;
					pend_seq_q      <= cand_seq_q;
					pend_earliest_q <= sres.found ? sres.deadline : '0;
					pend_held_q     <= held_q;
				end
			end
			S_TICK_NEXT: begin
				// look ahead so the word can carry last
				if (scan_done) begin
					pend_last_q <= !due;
					if (due) begin
						cand_idx_q  <= best_idx;
						cand_conn_q <= sres.conn;
						cand_seq_q  <= sres.seq;
					end
				end
			end
			S_FINAL: begin
				if (scan_done) begin
					pend_earliest_q <= sres.found ? sres.deadline : '0;
					pend_held_q     <= held_q;
				end
			end
			default: ;
		endcase
		if (emit_load) begin
			status_q   <= pend_status_q;
			exp_conn_q <= pend_conn_q;
			exp_seq_q  <= pend_seq_q;
			removed_q  <= pend_removed_q;
			count_q    <= pend_held_q;
			earliest_q <= pend_earliest_q;
			last_q     <= pend_last_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign expired_conn      = exp_conn_q;
	assign expired_sequence  = exp_seq_q;
	assign removed_count     = CNT_OUT_W'(removed_q);
	assign queue_count       = CNT_OUT_W'(count_q);
	assign earliest_deadline = earliest_q;
	assign last              = last_q;

endmodule

>>> hw/rtl/dtq_checker.sv
module dtq_checker
	import dtq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [2:0]           status,
	input logic [CONN_W-1:0]    expired_conn,
	input logic [SEQ_W-1:0]     expired_sequence,
	input logic [CNT_OUT_W-1:0] removed_count,
	input logic                 last
);

	// only a tick can give more than one word
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_EXPIRED) |-> last)
		else $error("non-expiry word without last");

	a_expiry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_EXPIRED) |->
			(expired_conn == '0) && (expired_sequence == '0))
		else $error("timer fields set on a non-expiry word");

	a_removed_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_REMOVED) |-> (removed_count == '0))
		else $error("removed count set on a word that removed nothing");

	// an accepted item always leaves the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
		else $error("stalled word changed");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.expired_conn     (expired_conn),
	.expired_sequence (expired_sequence),
	.removed_count    (removed_count),
	.last             (last)
);

>>> tb/deadline_timer_queue_checker.sv
module deadline_timer_queue_checker
	import dtq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	input  logic                 pready,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [CONN_W-1:0]    conn_id,
	input  logic [SEQ_W-1:0]     sequence_req,
	input  logic [DL_W-1:0]      now,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           status,
	input  logic [CONN_W-1:0]    expired_conn,
	input  logic [SEQ_W-1:0]     expired_sequence,
	input  logic [CNT_OUT_W-1:0] removed_count,
	input  logic [CNT_OUT_W-1:0] queue_count,
	input  logic [DL_W-1:0]      earliest_deadline,
	input  logic                 last,
	output int                   fail_count,
	output int                   pending_words,
	output int                   words_in,
	output int                   words_out,
	output int                   expired_words,
	output int                   full_words,
	output int                   renumbers
);

	typedef struct packed {
		status_t              status;
		logic [CONN_W-1:0]    conn;
		logic [SEQ_W-1:0]     seq;
		logic [CNT_OUT_W-1:0] removed;
		logic [CNT_OUT_W-1:0] held;
		logic [DL_W-1:0]      earliest;
		logic                 last;
	} result_word_t;

	// timer table as the block should hold it
	logic              slot_used [QUEUE_DEPTH];
	logic [DL_W-1:0]   slot_due  [QUEUE_DEPTH];
	logic [CONN_W-1:0] slot_conn [QUEUE_DEPTH];
	logic [SEQ_W-1:0]  slot_seq  [QUEUE_DEPTH];
	logic [ORD_W-1:0]  slot_tag  [QUEUE_DEPTH];
	logic [ORD_W-1:0]  tag_next;
	int                held;
	logic [WAIT_W-1:0] wait_cfg;
	logic              kick_cfg;

	result_word_t due_words [$];
	result_word_t got_word;
	result_word_t want_word;

	// earliest deadline, ties broken by insertion tag
	function automatic int soonest(input logic [QUEUE_DEPTH-1:0] skip);
		int best;
		best = -1;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (slot_used[i] && !skip[i]) begin
				if (best < 0 || slot_due[i] < slot_due[best] ||
				    (slot_due[i] == slot_due[best] && slot_tag[i] < slot_tag[best]))
					best = i;
			end
		end
		return best;
	endfunction

	function automatic logic [DL_W-1:0] deadline_at(input logic [DL_W-1:0] t);
		logic [DL_W:0] sum;
		sum = {1'b0, t} + {{(DL_W + 1 - WAIT_W){1'b0}}, wait_cfg};
		return sum[DL_W] ? '1 : sum[DL_W-1:0];
	endfunction

	function automatic result_word_t snapshot(input status_t st, input logic [CONN_W-1:0] c,
			input logic [SEQ_W-1:0] s, input int removed, input logic fin);
		result_word_t w;
		int m;
		m = soonest('0);
		w.status   = st;
		w.conn     = c;
		w.seq      = s;
		w.removed  = CNT_OUT_W'(removed);
		w.held     = CNT_OUT_W'(held);
		w.earliest = (m < 0) ? '0 : slot_due[m];
		w.last     = fin;
		return w;
	endfunction

	// compact the tags to 0..n-1, keeping their order
	task automatic renumber_tags();
		logic [ORD_W-1:0] rank [QUEUE_DEPTH];
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			rank[i] = '0;
			if (slot_used[i]) begin
				for (int j = 0; j < QUEUE_DEPTH; j++)
					if (slot_used[j] && slot_tag[j] < slot_tag[i])
						rank[i] = rank[i] + 1'b1;
			end
		end
		for (int i = 0; i < QUEUE_DEPTH; i++)
			if (slot_used[i])
				slot_tag[i] = rank[i];
		tag_next = ORD_W'(held);
		renumbers++;
	endtask

	task automatic take_tag(output logic [ORD_W-1:0] tag);
		if (tag_next >= ORDER_LIMIT)
			renumber_tags();
		tag = tag_next;
		tag_next = tag_next + 1'b1;
	endtask

	task automatic predict(input action_t act, input logic [CONN_W-1:0] c,
			input logic [SEQ_W-1:0] s, input logic [DL_W-1:0] t_now);
		result_word_t w [QUEUE_DEPTH];
		logic [QUEUE_DEPTH-1:0] seen;
		int n;
		int m;
		int slot;
		int removed;
		n = 0;
		seen = '0;
		slot = -1;
		removed = 0;
		case (act)
			ACT_ADD: begin
				for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
					if (!slot_used[i])
						slot = i;
				if (slot < 0) begin
					w[0] = snapshot(STAT_FULL, '0, '0, 0, 1'b1);
					full_words++;
				end else begin
					slot_due[slot]  = deadline_at(t_now);
					slot_conn[slot] = c;
					slot_seq[slot]  = s;
					take_tag(slot_tag[slot]);
					slot_used[slot] = 1'b1;
					held++;
					w[0] = snapshot(STAT_ADDED, '0, '0, 0, 1'b1);
				end
				n = 1;
			end
			ACT_TICK: begin
				m = soonest('0);
				if (m < 0 || !(slot_due[m] < t_now)) begin
					w[0] = snapshot(STAT_NONE, '0, '0, 0, 1'b1);
					n = 1;
				end else begin
					// each timer at most once, re-armed ones are not looked at again
					while (n < QUEUE_DEPTH) begin
						m = soonest(seen);
						if (m < 0 || slot_due[m] > t_now)
							break;
						seen[m] = 1'b1;
						if (kick_cfg) begin
							slot_used[m] = 1'b0;
							held--;
						end else begin
							slot_due[m] = deadline_at(t_now);
							take_tag(slot_tag[m]);
						end
						w[n] = snapshot(STAT_EXPIRED, slot_conn[m], slot_seq[m], 0, 1'b0);
						n++;
					end
					w[n-1].last = 1'b1;
					expired_words += n;
				end
			end
			ACT_DELETE: begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (slot_used[i] && slot_conn[i] == c) begin
						slot_used[i] = 1'b0;
						held--;
						removed++;
					end
				end
				w[0] = snapshot(STAT_REMOVED, '0, '0, removed, 1'b1);
				n = 1;
			end
			ACT_CLEAR: begin
				removed = held;
				for (int i = 0; i < QUEUE_DEPTH; i++)
					slot_used[i] = 1'b0;
				held = 0;
				tag_next = '0;
				w[0] = snapshot(STAT_REMOVED, '0, '0, removed, 1'b1);
				n = 1;
			end
		endcase
		for (int k = 0; k < n; k++)
			due_words.push_back(w[k]);
	endtask

	task automatic report_word(input string what, input result_word_t want,
			input result_word_t got);
		if (fail_count < 10) begin
			$display("%s at result word %0d", what, words_out);
			$display("  expected status %0d conn %h seq %h removed %0d count %0d earliest %h last %b",
				want.status, want.conn, want.seq, want.removed, want.held, want.earliest,
				want.last);
			$display("  got      status %0d conn %h seq %h removed %0d count %0d earliest %h last %b",
				got.status, got.conn, got.seq, got.removed, got.held, got.earliest, got.last);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_used[i] = 1'b0;
			tag_next      = '0;
			held          = 0;
			wait_cfg      = WAIT_RESET;
			kick_cfg      = 1'b0;
			due_words.delete();
			fail_count    = 0;
			pending_words = 0;
			words_in      = 0;
			words_out     = 0;
			expired_words = 0;
			full_words    = 0;
			renumbers     = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_sel_t'(paddr[2]))
					REG_WAIT: wait_cfg = pwdata[WAIT_W-1:0];
					REG_KICK: kick_cfg = pwdata[0];
				endcase
			end
			// words leaving belong to items taken earlier, so check before predicting
			if (out_valid && out_ready) begin
				got_word.status   = status_t'(status);
				got_word.conn     = expired_conn;
				got_word.seq      = expired_sequence;
				got_word.removed  = removed_count;
				got_word.held     = queue_count;
				got_word.earliest = earliest_deadline;
				got_word.last     = last;
				if (due_words.size() == 0) begin
					report_word("unexpected word", '0, got_word);
				end else begin
					want_word = due_words.pop_front();
					if (got_word.status !== want_word.status || got_word.conn !== want_word.conn ||
					    got_word.seq !== want_word.seq || got_word.removed !== want_word.removed ||
					    got_word.held !== want_word.held ||
					    got_word.earliest !== want_word.earliest ||
					    got_word.last !== want_word.last)
						report_word("mismatch", want_word, got_word);
				end
				words_out++;
			end
			if (in_valid && in_ready) begin
				predict(action_t'(action), conn_id, sequence_req, now);
				words_in++;
			end
			pending_words = due_words.size();
		end
	end

endmodule

>>> tb/deadline_timer_queue_tb.sv
module deadline_timer_queue_tb;
	import dtq_pkg::*;

	localparam int unsigned QUEUE_DEPTH   = 16;
	localparam int unsigned RANDOM_WORDS  = 450;
	// enough full-table re-arms to run the order tags out once
	localparam int unsigned EXHAUST_TICKS = 4100;
	localparam int unsigned SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
	localparam longint      CYCLE_LIMIT   = 64'd8_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           action;
	logic [CONN_W-1:0]    conn_id;
	logic [SEQ_W-1:0]     sequence_req;
	logic [DL_W-1:0]      now;
	logic                 out_valid;
	logic                 out_ready = 1'b1;
	logic [2:0]           status;
	logic [CONN_W-1:0]    expired_conn;
	logic [SEQ_W-1:0]     expired_sequence;
	logic [CNT_OUT_W-1:0] removed_count;
	logic [CNT_OUT_W-1:0] queue_count;
	logic [DL_W-1:0]      earliest_deadline;
	logic                 last;

	int     fail_count;
	int     pending_words;
	int     words_in;
	int     words_out;
	int     expired_words;
	int     full_words;
	int     renumbers;
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     wait_now;
	longint cycle_count = 0;

	deadline_timer_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.conn_id(conn_id),
		.sequence_req(sequence_req),
		.now(now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.expired_conn(expired_conn),
		.expired_sequence(expired_sequence),
		.removed_count(removed_count),
		.queue_count(queue_count),
		.earliest_deadline(earliest_deadline),
		.last(last)
	);

	deadline_timer_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.conn_id(conn_id),
		.sequence_req(sequence_req),
		.now(now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.expired_conn(expired_conn),
		.expired_sequence(expired_sequence),
		.removed_count(removed_count),
		.queue_count(queue_count),
		.earliest_deadline(earliest_deadline),
		.last(last),
		.fail_count(fail_count),
		.pending_words(pending_words),
		.words_in(words_in),
		.words_out(words_out),
		.expired_words(expired_words),
		.full_words(full_words),
		.renumbers(renumbers)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_word(input action_t act, input logic [CONN_W-1:0] c,
			input logic [SEQ_W-1:0] s, input logic [DL_W-1:0] t);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct)
			@(negedge clk);
		in_valid     <= 1'b1;
		action       <= act;
		conn_id      <= c;
		sequence_req <= s;
		now          <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input reg_sel_t r, input logic [PDATA_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every word owed has left and the block takes items again
	task automatic settle();
		@(negedge clk);
		while (pending_words != 0 || !in_ready)
			@(negedge clk);
	endtask

	task automatic set_mode(input int w, input logic k);
		settle();
		write_reg(REG_WAIT, PDATA_W'(w));
		write_reg(REG_KICK, PDATA_W'(k));
		wait_now = w;
	endtask

	task automatic run_phase(input int count, input int idle, input int stall,
			input logic [DL_W-1:0] base);
		logic [CONN_W-1:0] pool [4];
		logic [CONN_W-1:0] c;
		logic [DL_W-1:0]   t;
		int                pick;
		idle_pct = idle;
		stall_pct = stall;
		for (int k = 0; k < 4; k++)
			pool[k] = CONN_W'($urandom);
		t = base;
		repeat (count) begin
			if ($urandom_range(0, 39) == 0)
				settle();
			c = ($urandom_range(0, 7) == 0) ? CONN_W'($urandom) : pool[$urandom_range(0, 3)];
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				t += $urandom_range(0, 3);
				send_word(ACT_ADD, c, $urandom, t);
			end else if (pick < 80) begin
				t += $urandom_range(0, 2 * wait_now);
				send_word(ACT_TICK, c, $urandom, t);
			end else if (pick < 92) begin
				send_word(ACT_DELETE, c, $urandom, t);
			end else if (pick < 95) begin
				send_word(ACT_CLEAR, c, $urandom, t);
			end else begin
				send_word(action_t'($urandom_range(0, 3)), CONN_W'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		action       = ACT_ADD;
		conn_id      = '0;
		sequence_req = '0;
		now          = '0;
		wait_now     = WAIT_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: wait 20, re-arm
		send_word(ACT_TICK, '0, '0, '0);
		send_word(ACT_DELETE, '0, '0, '0);
		send_word(ACT_ADD, '1, '1, '0);
		send_word(ACT_ADD, '0, '0, '0);
		// deadline equal to now is not yet due
		send_word(ACT_TICK, '0, '0, 32'd20);
		send_word(ACT_TICK, '0, '0, 32'd21);
		send_word(ACT_ADD, 16'h0005, 32'h5555_AAAA, 32'hFFFF_FFF0);
		send_word(ACT_ADD, 16'h0005, 32'hAAAA_5555, '1);
		// re-armed deadlines saturate at now, each timer still comes out once
		send_word(ACT_TICK, '0, '0, '1);
		send_word(ACT_DELETE, 16'h0005, '0, '0);
		for (int k = 0; k < 15; k++)
			send_word(ACT_ADD, (k < 8) ? 16'h00C3 : 16'h3C00, $urandom, 32'h8000_0000 + k);
		send_word(ACT_DELETE, 16'h00C3, '0, '0);
		send_word(ACT_CLEAR, '0, '0, '0);

		// keep a full table re-arming until the order tags run out
		set_mode(1, 1'b0);
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_word(ACT_ADD, CONN_W'(k * 4099), $urandom, 32'd1000);
		for (int k = 0; k < EXHAUST_TICKS; k++)
			send_word(ACT_TICK, '0, '0, 32'd1002 + 2 * k);
		send_word(ACT_CLEAR, '0, '0, '0);

		run_phase(RANDOM_WORDS / 4, 0, 0, $urandom_range(0, 32'h7FFF_FFFF));
		set_mode(65535, 1'b1);
		run_phase(RANDOM_WORDS / 4, 65, 0, 32'hFFF0_0000);
		set_mode(9, 1'b1);
		run_phase(RANDOM_WORDS / 4, 0, 65, $urandom);
		set_mode(300, 1'b0);
		run_phase(RANDOM_WORDS / 4, 23, 23, $urandom);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d input words and %0d result words, %0d expired timers",
			words_in, words_out, expired_words);
		$display("%0d adds refused on a full table, %0d tag renumberings, wait 1..65535, kick 0/1",
			full_words, renumbers);
		if (fail_count == 0 && pending_words == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
